// ===== rtl/bdlp_pkg.sv =====
// Shared types and constants for the button debounce and long-press block.
package bdlp_pkg;

    localparam logic       OP_TICK  = 1'b0;
    localparam logic       OP_QUERY = 1'b1;

    localparam logic [1:0] STATUS_NORMAL  = 2'd0;
    localparam logic [1:0] STATUS_PRESSED = 2'd1;
    localparam logic [1:0] STATUS_LONG    = 2'd2;

    localparam logic [15:0] HOLD_TICKS_RESET = 16'd200;
    localparam int          PIN_BITS         = 4;
    localparam int          QUERY_SLOTS      = 4;

    typedef struct packed {
        logic tick;
        logic clr_long;
        logic clr_press;
    } lane_ctrl_t;

    typedef struct packed {
        logic long_press;
        logic press;
    } lane_stat_t;

endpackage

// ===== rtl/bdlp_lane.sv =====
// One button: three-sample debounce, hold counter and sticky flags.
module bdlp_lane
    import bdlp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  lane_ctrl_t  ctrl,
    input  logic        level,
    input  logic [15:0] hold_ticks,
    output lane_stat_t  stat
);

    logic [2:0]  hist_reg, hist_next;
    logic        rel_reg, rel_next;
    logic [15:0] cnt_reg, cnt_next;
    logic        press_reg, press_next;
    logic        long_reg, long_next;

    always_comb begin
        hist_next  = hist_reg;
        rel_next   = rel_reg;
        cnt_next   = cnt_reg;
        press_next = press_reg;
        long_next  = long_reg;
        if (ctrl.tick) begin
            hist_next = {hist_reg[1:0], level};
            if (hist_next == 3'b000) begin
                priority if (rel_reg) begin
                    press_next = 1'b1;
                    rel_next   = 1'b0;
                    cnt_next   = hold_ticks;
                end else if (cnt_reg == 16'd0) begin
                    // repeat: flag and reload
                    long_next = 1'b1;
                    cnt_next  = hold_ticks;
                end else begin
                    cnt_next = cnt_reg - 16'd1;
                end
            end else begin
                rel_next = 1'b1;
                cnt_next = hold_ticks;
            end
        end
        if (ctrl.clr_long) begin
            long_next = 1'b0;
        end
        if (ctrl.clr_press) begin
            press_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_reg  <= 3'b111;
            rel_reg   <= 1'b1;
            cnt_reg   <= HOLD_TICKS_RESET;
            press_reg <= 1'b0;
            long_reg  <= 1'b0;
        end else begin
            hist_reg  <= hist_next;
            rel_reg   <= rel_next;
            cnt_reg   <= cnt_next;
            press_reg <= press_next;
            long_reg  <= long_next;
        end
    end

    assign stat.long_press = long_reg;
    assign stat.press      = press_reg;

endmodule

// ===== rtl/bdlp_merge.sv =====
// Query merge: picks the addressed lane, encodes its status, clears the reported flag.
module bdlp_merge
    import bdlp_pkg::*;
#(
    parameter int NUM_BUTTONS = 4
) (
    input  logic                   query,
    input  logic [1:0]             button_index,
    input  lane_stat_t             stat [NUM_BUTTONS],
    output logic [1:0]             status,
    output logic [NUM_BUTTONS-1:0] clr_long,
    output logic [NUM_BUTTONS-1:0] clr_press
);

    lane_stat_t slot [QUERY_SLOTS];
    lane_stat_t sel;

    // Indexes with no lane read as idle flags, so they answer normal.
    for (genvar i = 0; i < QUERY_SLOTS; i++) begin : g_slot
        if (i < NUM_BUTTONS) begin : g_real
            assign slot[i] = stat[i];
        end else begin : g_none
            assign slot[i] = '0;
        end
    end

    assign sel = slot[button_index];

    always_comb begin
        priority if (sel.long_press) begin
            status = STATUS_LONG;
        end else if (sel.press) begin
            status = STATUS_PRESSED;
        end else begin
            status = STATUS_NORMAL;
        end
    end

    for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_clr
        if (i < QUERY_SLOTS) begin : g_addr
            assign clr_long[i]  = query && (button_index == 2'(i)) && sel.long_press;
            assign clr_press[i] = query && (button_index == 2'(i)) && !sel.long_press
                                  && sel.press;
        end else begin : g_unaddr
            assign clr_long[i]  = 1'b0;
            assign clr_press[i] = 1'b0;
        end
    end

endmodule

// ===== rtl/button_debounce_long_press.sv =====
// Top level: button debounce and long-press detector with stream ports.
// Throughput: one transaction per cycle, ticks and queries alike, while s_tready is high.
// Latency: a query's answer is on m_tvalid in the cycle after acceptance when no earlier answer waits.
// A two-entry output stage (register plus skid) keeps s_tready high while one answer waits.
// Reset (aresetn low, synchronous): all buttons released, flags clear, hold_ticks = 200.
module button_debounce_long_press
    import bdlp_pkg::*;
#(
    parameter int NUM_BUTTONS = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,  // hold_ticks
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,      // [3:0] pin_levels, [5:4] button_index, [7:6] zero
    input  logic        s_tuser,      // [0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata       // [1:0] button_status, [7:2] zero
);

    logic [15:0] hold_reg;
    logic        s_acc, push, pop;
    logic [3:0]  pins;
    logic [1:0]  idx;
    logic [1:0]  status;

    lane_ctrl_t             ctrl [NUM_BUTTONS];
    lane_stat_t             stat [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0] clr_long, clr_press;

    logic       out_valid_reg, out_valid_next;
    logic [1:0] out_data_reg, out_data_next;
    logic       skid_valid_reg, skid_valid_next;
    logic [1:0] skid_data_reg, skid_data_next;

    assign pins  = s_tdata[3:0];
    assign idx   = s_tdata[5:4];
    assign s_acc = s_tvalid && s_tready;
    assign push  = s_acc && (s_tuser == OP_QUERY);
    assign pop   = out_valid_reg && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_reg <= HOLD_TICKS_RESET;
        end else if (cfg_wr_en) begin
            hold_reg <= cfg_wr_data;
        end
    end

    for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
        logic level;
        if (i < PIN_BITS) begin : g_pin
            assign level = pins[i];
        end else begin : g_high
            assign level = 1'b1;
        end
        assign ctrl[i].tick      = s_acc && (s_tuser == OP_TICK);
        assign ctrl[i].clr_long  = clr_long[i];
        assign ctrl[i].clr_press = clr_press[i];

        bdlp_lane u_lane (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl[i]),
            .level      (level),
            .hold_ticks (hold_reg),
            .stat       (stat[i])
        );
    end

    bdlp_merge #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_merge (
        .query        (push),
        .button_index (idx),
        .stat         (stat),
        .status       (status),
        .clr_long     (clr_long),
        .clr_press    (clr_press)
    );

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        priority if (!out_valid_reg) begin
            out_valid_next = push;
            out_data_next  = status;
        end else if (pop) begin
            // advance skid into the output; no push can arrive while skid is full
            if (skid_valid_reg) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = push;
                out_data_next  = status;
            end
        end else if (push) begin
            skid_valid_next = 1'b1;
            skid_data_next  = status;
        end else begin
            // hold both entries
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign s_tready = !skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_data_reg};

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds data while output register is empty");

    a_query_answered: assert property (@(posedge aclk) disable iff (!aresetn)
        push |=> m_tvalid)
        else $error("accepted query produced no answer");

    a_one_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (|{clr_long, clr_press}) |-> ($onehot0({clr_long, clr_press}) && push))
        else $error("flag clear outside a single query");

    a_long_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (|clr_long) |=> (!skid_valid_reg ? out_data_reg == STATUS_LONG
                                         : skid_data_reg == STATUS_LONG))
        else $error("long-press clear without long-press answer");
`endif

endmodule
